/* hdl/cpd_pkg.sv */
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants for the command packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // payload capacity in bytes (2..64)
    localparam int          MAX_PAYLOAD = 64;
    localparam int          IDX_W       = $clog2(MAX_PAYLOAD);
    localparam logic [7:0]  MAX_LEN     = 8'(MAX_PAYLOAD);
    localparam int          BIDX_W      = 6;   // byte_index field width

    localparam logic [7:0]  START_A_RST = 8'h12;
    localparam logic [7:0]  START_B_RST = 8'h34;

    // request kind on the slave side tuser
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_FETCH = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // config register index
    typedef enum logic [0:0] {
        REG_START_A = 1'b0,
        REG_START_B = 1'b1
    } t_cfg_reg;

    // one decoded fetch or query, front to back
    typedef struct packed {
        logic             available;
        logic [7:0]       command;
        logic [7:0]       pkt_len;
        logic [7:0]       crc;
        logic             truncated;
        logic             dropped;
        logic             use_ram;    // stream stored data bytes
        logic [IDX_W-1:0] last_idx;   // index of final result
    } t_cmd;

    // payload RAM write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_ram_wr;

    // one result
    typedef struct packed {
        logic              available;
        logic [7:0]        command;
        logic [7:0]        pkt_len;
        logic [7:0]        crc;
        logic [7:0]        data_byte;
        logic [BIDX_W-1:0] byte_index;
        logic              truncated;
        logic              dropped;
        logic              last;
    } t_res;

endpackage

/* hdl/cpd_ram.sv */
// ----------------------------------------------------------------------------
// cpd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/cpd_front.sv */
// ----------------------------------------------------------------------------
// cpd_front
// Frame recognizer and request classifier: parses received bytes into the
// packet buffer and turns fetch / query requests into queue entries.
// ----------------------------------------------------------------------------
module cpd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,
    input  logic [1:0]          i_s_tuser,
    input  logic                i_q_full,
    input  logic                i_rd_busy,
    output logic                o_push,
    output cpd_pkg::t_cmd       o_cmd,
    output cpd_pkg::t_ram_wr    o_ram_wr
);

    typedef enum logic [5:0] {
        PH_START_A = 6'b000001,
        PH_START_B = 6'b000010,
        PH_COMMAND = 6'b000100,
        PH_LENGTH  = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_CRC     = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_start_a, n_start_a;
    logic [7:0] r_start_b, n_start_b;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_len, n_len;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_crc, n_crc;
    logic       r_pkt_rdy, n_pkt_rdy;
    logic       r_drop, n_drop;

    logic       accept;
    logic       cfg_we;
    logic [7:0] stored;
    logic [7:0] stored_m1;
    logic [7:0] cnt_inc;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // bytes wait while a fetch still reads the payload RAM
    assign o_s_tready = !i_q_full &&
                        !((i_s_tuser == cpd_pkg::OP_BYTE) && i_rd_busy);
    assign accept     = i_s_tvalid && o_s_tready;

    assign stored    = (r_len > cpd_pkg::MAX_LEN) ? cpd_pkg::MAX_LEN : r_len;
    assign stored_m1 = (stored == 8'd0) ? 8'd0 : stored - 8'd1;
    assign cnt_inc   = r_cnt + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_start_a = r_start_a;
        n_start_b = r_start_b;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_crc     = r_crc;
        n_pkt_rdy = r_pkt_rdy;
        n_drop    = r_drop;
        o_push    = 1'b0;
        o_cmd     = '0;
        o_ram_wr  = '0;

        if (cfg_we) begin
            case (i_cfg_index)
                cpd_pkg::REG_START_A: n_start_a = i_cfg_data;
                cpd_pkg::REG_START_B: n_start_b = i_cfg_data;
                default: ;
            endcase
        end

        if (accept) begin
            case (i_s_tuser)
                cpd_pkg::OP_BYTE: begin
                    case (r_phase)
                        PH_START_B: begin
                            if (i_s_tdata == r_start_b) begin
                                n_phase = PH_COMMAND;
                            end
                        end
                        PH_COMMAND: begin
                            n_cmd   = i_s_tdata;
                            n_phase = PH_LENGTH;
                        end
                        PH_LENGTH: begin
                            n_len   = i_s_tdata;
                            n_cnt   = 8'd0;
                            n_phase = (i_s_tdata == 8'd0) ? PH_CRC : PH_DATA;
                        end
                        PH_DATA: begin
                            // bytes past capacity are counted, not stored
                            if (r_cnt < cpd_pkg::MAX_LEN) begin
                                o_ram_wr.en   = 1'b1;
                                o_ram_wr.addr = r_cnt[cpd_pkg::IDX_W-1:0];
                                o_ram_wr.data = i_s_tdata;
                            end
                            n_cnt = cnt_inc;
                            if (cnt_inc == r_len) begin
                                n_phase = PH_CRC;
                            end
                        end
                        PH_CRC: begin
                            n_crc     = i_s_tdata;
                            n_pkt_rdy = 1'b1;
                            n_phase   = PH_START_A;
                        end
                        default: begin
                            n_phase = PH_START_A;
                            if (i_s_tdata == r_start_a) begin
                                if (r_pkt_rdy) begin
                                    n_drop = 1'b1;
                                end else begin
                                    n_phase = PH_START_B;
                                end
                            end
                        end
                    endcase
                end
                cpd_pkg::OP_FETCH: begin
                    o_push = 1'b1;
                    if (r_pkt_rdy) begin
                        o_cmd.available = 1'b1;
                        o_cmd.command   = r_cmd;
                        o_cmd.pkt_len   = r_len;
                        o_cmd.crc       = r_crc;
                        o_cmd.truncated = (r_len > cpd_pkg::MAX_LEN);
                        o_cmd.use_ram   = (r_len != 8'd0);
                        o_cmd.last_idx  = stored_m1[cpd_pkg::IDX_W-1:0];
                        n_pkt_rdy       = 1'b0;
                    end
                end
                cpd_pkg::OP_QUERY: begin
                    o_push        = 1'b1;
                    o_cmd.dropped = r_drop;
                    n_drop        = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START_A;
            r_start_a <= cpd_pkg::START_A_RST;
            r_start_b <= cpd_pkg::START_B_RST;
            r_cmd     <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_crc     <= '0;
            r_pkt_rdy <= 1'b0;
            r_drop    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_start_a <= n_start_a;
            r_start_b <= n_start_b;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_crc     <= n_crc;
            r_pkt_rdy <= n_pkt_rdy;
            r_drop    <= n_drop;
        end
    end

endmodule

/* hdl/cpd_queue.sv */
// ----------------------------------------------------------------------------
// cpd_queue
// Two-entry request queue between front and back; also tracks how many
// queued fetches will read the payload RAM.
// ----------------------------------------------------------------------------
module cpd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output cpd_pkg::t_cmd o_head,
    output logic          o_ram_pending
);

    cpd_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic [1:0]    r_ram_cnt, n_ram_cnt;
    logic          do_push, do_pop;

    assign o_full        = (r_count == 2'd2);
    assign o_empty       = (r_count == 2'd0);
    assign o_head        = r_mem[r_rd_ptr];
    assign o_ram_pending = (r_ram_cnt != 2'd0);

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count   = r_count;
        n_ram_cnt = r_ram_cnt;
        if (do_push) begin
            n_count = n_count + 2'd1;
            if (i_cmd.use_ram) begin
                n_ram_cnt = n_ram_cnt + 2'd1;
            end
        end
        if (do_pop) begin
            n_count = n_count - 2'd1;
            if (o_head.use_ram) begin
                n_ram_cnt = n_ram_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_count   <= '0;
            r_ram_cnt <= '0;
        end else begin
            r_wr_ptr  <= r_wr_ptr ^ do_push;
            r_rd_ptr  <= r_rd_ptr ^ do_pop;
            r_count   <= n_count;
            r_ram_cnt <= n_ram_cnt;
        end
    end

endmodule

/* hdl/cpd_back.sv */
// ----------------------------------------------------------------------------
// cpd_back
// Result sequencer: expands each queued request into results, reads the
// payload RAM and holds results in an output register.
// ----------------------------------------------------------------------------
module cpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  cpd_pkg::t_cmd               i_q_head,
    output logic                        o_pop,
    output logic                        o_ram_busy,
    output logic                        o_rd_en,
    output logic [cpd_pkg::IDX_W-1:0]   o_rd_addr,
    input  logic [7:0]                  i_rd_data,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output cpd_pkg::t_res               o_res
);

    logic                      r_busy;
    cpd_pkg::t_cmd             r_cur;
    logic [cpd_pkg::IDX_W-1:0] r_k;

    // stage 1: RAM read in flight, stage 2: output register
    logic          r_s1_valid;
    cpd_pkg::t_res r_s1;
    logic          r_s1_ram;
    logic          r_s2_valid;
    cpd_pkg::t_res r_s2;

    logic          adv;
    logic          s1_free;
    logic          issue;
    logic          k_last;
    cpd_pkg::t_res s1_new;
    cpd_pkg::t_res s2_new;

    assign adv     = !r_s2_valid || i_m_tready;
    assign s1_free = !r_s1_valid || adv;
    assign issue   = r_busy && s1_free;
    assign k_last  = (r_k == r_cur.last_idx);
    assign o_pop   = !r_busy && !i_q_empty;

    assign o_ram_busy = r_busy && r_cur.use_ram;
    assign o_rd_en    = issue && r_cur.use_ram;
    assign o_rd_addr  = r_k;

    always_comb begin
        s1_new            = '0;
        s1_new.available  = r_cur.available;
        s1_new.command    = r_cur.command;
        s1_new.pkt_len    = r_cur.pkt_len;
        s1_new.crc        = r_cur.crc;
        s1_new.byte_index = cpd_pkg::BIDX_W'(r_k);
        s1_new.truncated  = r_cur.truncated;
        s1_new.dropped    = r_cur.dropped;
        s1_new.last       = k_last;
    end

    // RAM data joins the result on its way into the output register
    always_comb begin
        s2_new           = r_s1;
        s2_new.data_byte = r_s1_ram ? i_rd_data : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_head;
        end
        if (issue) begin
            r_s1     <= s1_new;
            r_s1_ram <= r_cur.use_ram;
        end
        if (r_s1_valid && adv) begin
            r_s2 <= s2_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_k        <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (issue) begin
                if (k_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k <= r_k + cpd_pkg::IDX_W'(1);
                end
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    assign o_m_tvalid = r_s2_valid;
    assign o_res      = r_s2;

endmodule

/* hdl/command_packet_deframer.sv */
// ----------------------------------------------------------------------------
// command_packet_deframer
// Length-prefixed command packet deframer with a one-packet buffer.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream; tuser selects the kind (received byte,
// fetch, query dropped flag) and tdata carries the byte. Received bytes are
// matched against start_a, start_b, command, length, data bytes, crc; one
// complete packet is held (up to 64 data bytes in a payload RAM, the rest
// counted but dropped and the packet marked truncated). A start_a byte seen
// while a packet is held sets the sticky dropped flag. A fetch returns one
// result per stored data byte (one result if the length is zero, or a single
// all-zero result when nothing is held) and frees the buffer; a query returns
// and clears the dropped flag. A request is accepted unless held off: all
// requests wait while the two-entry queue is full, and since the payload RAM
// has one write and one read port, received bytes wait (tready low) while a
// queued or running fetch still has RAM reads to issue. A fetch streams one
// result per cycle once started, limited by the output handshake; the first
// result passes through the queue, the current-request register, the RAM read
// and the output register, and the back end pops the next queued request only
// after issuing the last result of the current one. The payload RAM is not
// cleared after reset; no startup pass.
module command_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,   // 0 start_a, 1 start_b
    input  logic [7:0]  i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] rx_byte
    input  logic [1:0]  i_s_tuser,     // [1:0] op
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,     // [7:0] command, [15:8] length byte,
                                       // [23:16] crc, [31:24] data_byte,
                                       // [37:32] byte_index, [38] truncated,
                                       // [39] dropped
    output logic        o_m_tuser,     // [0] available
    output logic        o_m_tlast      // last result of a fetch or query
);

    logic                      q_push;
    cpd_pkg::t_cmd             q_in;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    cpd_pkg::t_cmd             q_head;
    logic                      q_ram_pending;
    logic                      back_ram_busy;
    logic                      rd_busy;
    cpd_pkg::t_ram_wr          ram_wr;
    logic                      rd_en;
    logic [cpd_pkg::IDX_W-1:0] rd_addr;
    logic [7:0]                rd_data;
    cpd_pkg::t_res             res;

    // any fetch that still has RAM reads ahead of it
    assign rd_busy = q_ram_pending || back_ram_busy;

    cpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (q_full),
        .i_rd_busy   (rd_busy),
        .o_push      (q_push),
        .o_cmd       (q_in),
        .o_ram_wr    (ram_wr)
    );

    cpd_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (q_push),
        .i_cmd         (q_in),
        .i_pop         (q_pop),
        .o_full        (q_full),
        .o_empty       (q_empty),
        .o_head        (q_head),
        .o_ram_pending (q_ram_pending)
    );

    cpd_ram #(
        .WIDTH (8),
        .DEPTH (cpd_pkg::MAX_PAYLOAD)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_pop      (q_pop),
        .o_ram_busy (back_ram_busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (res)
    );

    assign o_m_tdata = {res.dropped, res.truncated, res.byte_index, res.data_byte,
                        res.crc, res.pkt_len, res.command};
    assign o_m_tuser = res.available;
    assign o_m_tlast = res.last;

endmodule

/* verif/tb_command_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_packet_deframer
// Self-checking bench: byte, fetch and query requests against a deframer model.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. Then frames are built from
// random content under several start-byte settings, mixed with noise and
// broken frames. Every accepted request runs through a local model of the
// deframer. Every result is checked field by field against the oldest
// reply still due. Both stream sides idle at random, and once the result
// side holds off long enough to back the request side up.
// ----------------------------------------------------------------------------
module tb_command_packet_deframer;

    localparam int LONG_HOLD      = 400;   // receiver hold-off for back-pressure
    localparam int SETTLE_CYCLES  = 8;     // extra wait in settle after the last reply
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all

    // receive-side framing phases
    typedef enum logic [5:0] {
        FR_START_A = 6'b000001,
        FR_START_B = 6'b000010,
        FR_COMMAND = 6'b000100,
        FR_LENGTH  = 6'b001000,
        FR_DATA    = 6'b010000,
        FR_CRC     = 6'b100000
    } t_frame_phase;

    // one directed request; res is typed in only where pinned is set
    typedef struct {
        cpd_pkg::t_op  op;
        logic [7:0]    rx;
        bit            pinned;
        cpd_pkg::t_res res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    command_packet_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Deframer model: state, configuration and the replies still due
    // ------------------------------------------------------------------
    t_frame_phase  fr_phase   = FR_START_A;
    logic [7:0]    fr_cmd     = 8'h00;
    logic [7:0]    fr_len     = 8'h00;
    logic [7:0]    fr_count   = 8'h00;
    logic [7:0]    fr_crc     = 8'h00;
    logic [7:0]    fr_payload [cpd_pkg::MAX_PAYLOAD];
    bit            fr_held    = 1'b0;   // complete packet waiting for a fetch
    bit            fr_dropped = 1'b0;   // sticky: frame start hit a full buffer
    logic [7:0]    cfg_start_a = cpd_pkg::START_A_RST;
    logic [7:0]    cfg_start_b = cpd_pkg::START_B_RST;
    cpd_pkg::t_res replies_due [$];

    // start bytes as the request side last wrote them
    logic [7:0]    tx_start_a = cpd_pkg::START_A_RST;
    logic [7:0]    tx_start_b = cpd_pkg::START_B_RST;

    bit            pin_on;
    cpd_pkg::t_res pin_res;
    bit            src_steady    = 1'b0;
    bit            sink_steady   = 1'b0;
    bit            long_hold_req = 1'b0;
    int            items_sent    = 0;
    int            idle_cycles   = 0;
    int            fail_count    = 0;
    t_stim_row     stim_table [$];

    function automatic void deframe_byte(logic [7:0] b);
        case (fr_phase)
            FR_START_B: begin
                // anything but start_b keeps us waiting for it
                if (b == cfg_start_b) fr_phase = FR_COMMAND;
            end
            FR_COMMAND: begin
                fr_cmd   = b;
                fr_phase = FR_LENGTH;
            end
            FR_LENGTH: begin
                fr_len   = b;
                fr_count = 8'h00;
                fr_phase = (b == 8'h00) ? FR_CRC : FR_DATA;
            end
            FR_DATA: begin
                // bytes past capacity are counted, not stored
                if (fr_count < cpd_pkg::MAX_LEN) fr_payload[fr_count] = b;
                fr_count = fr_count + 8'd1;
                if (fr_count == fr_len) fr_phase = FR_CRC;
            end
            FR_CRC: begin
                fr_crc   = b;
                fr_held  = 1'b1;
                fr_phase = FR_START_A;
            end
            default: begin
                fr_phase = FR_START_A;
                if (b == cfg_start_a) begin
                    if (fr_held) fr_dropped = 1'b1;
                    else fr_phase = FR_START_B;
                end
            end
        endcase
    endfunction

    function automatic void compute_replies(cpd_pkg::t_op op, logic [7:0] b);
        cpd_pkg::t_res r;
        int            stored;
        int            n;
        int            k;
        r = '0;
        case (op)
            cpd_pkg::OP_BYTE: deframe_byte(b);
            cpd_pkg::OP_QUERY: begin
                r.dropped  = fr_dropped;
                r.last     = 1'b1;
                fr_dropped = 1'b0;
                replies_due.push_back(r);
            end
            cpd_pkg::OP_FETCH: begin
                if (!fr_held) begin
                    r.last = 1'b1;
                    replies_due.push_back(r);
                end else begin
                    stored = (fr_len > cpd_pkg::MAX_LEN) ? cpd_pkg::MAX_PAYLOAD
                                                         : int'(fr_len);
                    n      = (stored == 0) ? 1 : stored;
                    for (k = 0; k < n; k++) begin
                        r.available  = 1'b1;
                        r.command    = fr_cmd;
                        r.pkt_len    = fr_len;
                        r.crc        = fr_crc;
                        r.data_byte  = (stored == 0) ? 8'h00 : fr_payload[k];
                        r.byte_index = cpd_pkg::BIDX_W'(k);
                        r.truncated  = (fr_len > cpd_pkg::MAX_LEN);
                        r.dropped    = 1'b0;
                        r.last       = (k == n - 1);
                        replies_due.push_back(r);
                    end
                    fr_held = 1'b0;
                end
            end
            default: ;  // unused kind: ignored
        endcase
    endfunction

    function automatic cpd_pkg::t_res mk_res(logic avail, logic [7:0] cmd,
                                             logic [7:0] len, logic [7:0] crc,
                                             logic [7:0] data,
                                             logic [cpd_pkg::BIDX_W-1:0] idx,
                                             logic trunc, logic drop, logic fin);
        cpd_pkg::t_res r;
        r.available  = avail;
        r.command    = cmd;
        r.pkt_len    = len;
        r.crc        = crc;
        r.data_byte  = data;
        r.byte_index = idx;
        r.truncated  = trunc;
        r.dropped    = drop;
        r.last       = fin;
        return r;
    endfunction

    function automatic void add_row(cpd_pkg::t_op op, logic [7:0] rx, bit pinned,
                                    cpd_pkg::t_res res);
        t_stim_row row;
        row.op     = op;
        row.rx     = rx;
        row.pinned = pinned;
        row.res    = res;
        stim_table.push_back(row);
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // data lengths: mostly small, a few around the capacity edge
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16) return $urandom_range(0, 6);
        if (r < 19) return $urandom_range(7, 40);
        return $urandom_range(60, 70);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: model update on every accepted request, result checks,
    // and the count of cycles with no handshake for the watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cpd_pkg::t_res want;
        bit            busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                busy = 1'b1;
                if (cpd_pkg::t_cfg_reg'(i_cfg_index) == cpd_pkg::REG_START_A)
                    cfg_start_a = i_cfg_data;
                else
                    cfg_start_b = i_cfg_data;
            end
            if (i_s_tvalid && o_s_tready) begin
                busy = 1'b1;
                compute_replies(cpd_pkg::t_op'(i_s_tuser), i_s_tdata);
                // a typed-in value stands in for the model's single reply
                if (pin_on) replies_due[replies_due.size() - 1] = pin_res;
            end
            if (o_m_tvalid && i_m_tready) begin
                busy = 1'b1;
                if (replies_due.size() == 0) begin
                    $error("unexpected result: tdata %h tuser %b tlast %b",
                           o_m_tdata, o_m_tuser, o_m_tlast);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("available", int'(want.available), int'(o_m_tuser));
                    check_field("command", int'(want.command), int'(o_m_tdata[7:0]));
                    check_field("pkt_len", int'(want.pkt_len), int'(o_m_tdata[15:8]));
                    check_field("crc", int'(want.crc), int'(o_m_tdata[23:16]));
                    check_field("data_byte", int'(want.data_byte),
                                int'(o_m_tdata[31:24]));
                    check_field("byte_index", int'(want.byte_index),
                                int'(o_m_tdata[37:32]));
                    check_field("truncated", int'(want.truncated), int'(o_m_tdata[38]));
                    check_field("dropped", int'(want.dropped), int'(o_m_tdata[39]));
                    check_field("last", int'(want.last), int'(o_m_tlast));
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random tready, steady stretches, one long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_tready    = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
            if (sink_steady || $urandom_range(0, 3) != 0) begin
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = 1'b0;
                repeat (pick_gap() - 1) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_req(cpd_pkg::t_op op, logic [7:0] b, bit pinned,
                            cpd_pkg::t_res res);
        @(negedge i_clk);
        if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
        if (!src_steady && $urandom_range(0, 3) == 0) begin
            i_s_tvalid = 1'b0;
            repeat (pick_gap()) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = b;
        pin_on     = pinned;
        pin_res    = res;
        do @(posedge i_clk); while (!o_s_tready);
        if (op != cpd_pkg::OP_NONE) items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_req(cpd_pkg::OP_BYTE, b, 1'b0, '0);
    endtask

    // whole frame; stutter puts stray bytes between the two start bytes
    task automatic send_frame(logic [7:0] cmd, logic [7:0] len, bit stutter);
        logic [7:0] b;
        send_byte(tx_start_a);
        if (stutter) begin
            repeat ($urandom_range(1, 2)) begin
                b = 8'($urandom);
                if (b == tx_start_b) b = b ^ 8'h01;
                send_byte(b);
            end
        end
        send_byte(tx_start_b);
        send_byte(cmd);
        send_byte(len);
        repeat (len) send_byte(8'($urandom));
        send_byte(8'($urandom));
    endtask

    task automatic write_reg(cpd_pkg::t_cfg_reg idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == cpd_pkg::REG_START_A) tx_start_a = val;
        else tx_start_b = val;
    endtask

    // stop offering, let every due reply arrive, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, the rest noise
    task automatic run_random(int count);
        int first;
        int r;
        first = items_sent;
        while (items_sent - first < count) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_frame(8'($urandom), 8'(pick_len()), $urandom_range(0, 5) == 0);
                if ($urandom_range(0, 4) != 0)
                    send_req(cpd_pkg::OP_FETCH, 8'($urandom), 1'b0, '0);
                else
                    send_req(cpd_pkg::OP_QUERY, 8'($urandom), 1'b0, '0);
            end else if (r < 75) begin
                if (r[0]) send_req(cpd_pkg::OP_FETCH, 8'($urandom), 1'b0, '0);
                else send_req(cpd_pkg::OP_QUERY, 8'($urandom), 1'b0, '0);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (r < 95) begin
                // frame cut short after the start bytes
                send_byte(tx_start_a);
                if (r[0]) send_byte(tx_start_b);
            end else begin
                send_req(cpd_pkg::OP_NONE, 8'($urandom), 1'b0, '0);
            end
        end
    endtask

    initial begin : main
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = cpd_pkg::REG_START_A;
        i_cfg_data  = 8'h00;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'h00;
        i_s_tuser   = cpd_pkg::OP_BYTE;
        pin_on      = 1'b0;
        pin_res     = '0;

        // directed requests under the reset start bytes 0x12 / 0x34
        add_row(cpd_pkg::OP_QUERY, 8'h00, 1'b1,
                mk_res(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        add_row(cpd_pkg::OP_FETCH, 8'hFF, 1'b1,
                mk_res(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        add_row(cpd_pkg::OP_NONE,  8'hFF, 1'b0, '0);
        add_row(cpd_pkg::OP_BYTE,  8'h12, 1'b0, '0);
        add_row(cpd_pkg::OP_BYTE,  8'h00, 1'b0, '0);   // wrong second start byte
        add_row(cpd_pkg::OP_BYTE,  8'h34, 1'b0, '0);
        add_row(cpd_pkg::OP_BYTE,  8'hFF, 1'b0, '0);   // command
        add_row(cpd_pkg::OP_BYTE,  8'h00, 1'b0, '0);   // zero length
        add_row(cpd_pkg::OP_BYTE,  8'hAB, 1'b0, '0);   // crc
        add_row(cpd_pkg::OP_BYTE,  8'h12, 1'b0, '0);   // frame start with the buffer full
        add_row(cpd_pkg::OP_QUERY, 8'h00, 1'b1,
                mk_res(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b1, 1'b1));
        add_row(cpd_pkg::OP_QUERY, 8'h00, 1'b1,
                mk_res(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        add_row(cpd_pkg::OP_FETCH, 8'h00, 1'b1,
                mk_res(1'b1, 8'hFF, 8'h00, 8'hAB, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        add_row(cpd_pkg::OP_FETCH, 8'h00, 1'b1,
                mk_res(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
        add_row(cpd_pkg::OP_BYTE,  8'h12, 1'b0, '0);
        add_row(cpd_pkg::OP_BYTE,  8'h34, 1'b0, '0);
        add_row(cpd_pkg::OP_BYTE,  8'h00, 1'b0, '0);   // command
        add_row(cpd_pkg::OP_BYTE,  8'h01, 1'b0, '0);   // length 1
        add_row(cpd_pkg::OP_BYTE,  8'hFF, 1'b0, '0);   // data
        add_row(cpd_pkg::OP_BYTE,  8'h00, 1'b0, '0);   // crc
        add_row(cpd_pkg::OP_FETCH, 8'h00, 1'b1,
                mk_res(1'b1, 8'h00, 8'h01, 8'h00, 8'hFF, 6'd0, 1'b0, 1'b0, 1'b1));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[i])
            send_req(stim_table[i].op, stim_table[i].rx, stim_table[i].pinned,
                     stim_table[i].res);

        // capacity edges: full store, one past it
        send_frame(8'h5A, cpd_pkg::MAX_LEN, 1'b0);
        send_req(cpd_pkg::OP_FETCH, 8'h00, 1'b0, '0);
        send_frame(8'hA5, cpd_pkg::MAX_LEN + 8'd1, 1'b0);
        send_req(cpd_pkg::OP_FETCH, 8'h00, 1'b0, '0);
        settle();

        write_reg(cpd_pkg::REG_START_A, 8'h00);
        write_reg(cpd_pkg::REG_START_B, 8'hFF);
        run_random(30);
        settle();

        write_reg(cpd_pkg::REG_START_A, 8'hFF);
        write_reg(cpd_pkg::REG_START_B, 8'h00);
        // receiver holds off while fetches and bytes pile up behind it
        long_hold_req = 1'b1;
        src_steady    = 1'b1;
        send_frame(8'($urandom), 8'd40, 1'b0);
        send_req(cpd_pkg::OP_FETCH, 8'h00, 1'b0, '0);
        send_req(cpd_pkg::OP_QUERY, 8'h00, 1'b0, '0);
        send_req(cpd_pkg::OP_FETCH, 8'h00, 1'b0, '0);
        send_frame(8'($urandom), 8'd3, 1'b0);
        send_req(cpd_pkg::OP_FETCH, 8'h00, 1'b0, '0);
        send_req(cpd_pkg::OP_QUERY, 8'h00, 1'b0, '0);
        run_random(30);
        settle();

        write_reg(cpd_pkg::REG_START_A, 8'($urandom));
        write_reg(cpd_pkg::REG_START_B, 8'($urandom));
        run_random(30);
        settle();

        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/cpd_pkg.sv
hdl/cpd_ram.sv
hdl/cpd_front.sv
hdl/cpd_queue.sv
hdl/cpd_back.sv
hdl/command_packet_deframer.sv
verif/tb_command_packet_deframer.sv
